FILE: sv/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and codes for the route conflict scoreboard.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // Default configuration
    localparam int           DEF_ENTRIES     = 8;
    localparam logic [7:0]   DEF_UNUSED_CODE = 8'd255;

    // Request modes
    localparam logic [1:0] MODE_CHECK   = 2'd0;
    localparam logic [1:0] MODE_RESERVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_PUMP    = 3'd1;
    localparam logic [2:0] ST_NO_SINK     = 3'd2;
    localparam logic [2:0] ST_NO_RELAY    = 3'd3;
    localparam logic [2:0] ST_SINK_BUSY   = 3'd4;
    localparam logic [2:0] ST_RELAY_BUSY  = 3'd5;
    localparam logic [2:0] ST_VALVE_BUSY  = 3'd6;

    // One reservation slot as read from the store
    typedef struct packed {
        logic       active;
        logic [3:0] sink;
        logic [7:0] prel;
        logic [7:0] vrel;
    } t_slot;

    // Store write controls
    typedef struct packed {
        logic wr_en;
        logic clr_all;
    } t_wr_ctl;

    // Compare unit verdict for one slot
    typedef struct packed {
        logic       hit;
        logic [2:0] status;
    } t_match;

endpackage

FILE: sv/rcs_slot_store.sv
// ----------------------------------------------------------------------------
// rcs_slot_store
// Reservation slots: active flags in resettable flops, payload in plain
// registers. One write port, one read port at the scan index.
// ----------------------------------------------------------------------------
module rcs_slot_store #(
    parameter int ENTRIES = rcs_pkg::DEF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcs_pkg::t_wr_ctl     i_wr,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  logic [3:0]           i_wr_sink,
    input  logic [7:0]           i_wr_prel,
    input  logic [7:0]           i_wr_vrel,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output rcs_pkg::t_slot       o_rd_slot
);

    logic [ENTRIES-1:0] r_active;
    logic [3:0]         r_sink [ENTRIES];
    logic [7:0]         r_prel [ENTRIES];
    logic [7:0]         r_vrel [ENTRIES];

    // Active flags: cleared by reset and by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr.clr_all) begin
            r_active <= '0;
        end else if (i_wr.wr_en) begin
            r_active[i_wr_idx] <= 1'b1;
        end
    end

    // Payload: only read behind an active flag, so no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_sink[i_wr_idx] <= i_wr_sink;
            r_prel[i_wr_idx] <= i_wr_prel;
            r_vrel[i_wr_idx] <= i_wr_vrel;
        end
    end

    // Read port
    always_comb begin
        o_rd_slot.active = r_active[i_rd_idx];
        o_rd_slot.sink   = r_sink[i_rd_idx];
        o_rd_slot.prel   = r_prel[i_rd_idx];
        o_rd_slot.vrel   = r_vrel[i_rd_idx];
    end

endmodule

FILE: sv/rcs_match_unit.sv
// ----------------------------------------------------------------------------
// rcs_match_unit
// Shared compare unit: tests one stored slot against the request, in the
// order sink, pump relay, valve relay. Unused relay codes never match.
// ----------------------------------------------------------------------------
module rcs_match_unit #(
    parameter logic [7:0] UNUSED_CODE = rcs_pkg::DEF_UNUSED_CODE
) (
    input  rcs_pkg::t_slot  i_slot,
    input  logic            i_own,
    input  logic [3:0]      i_sink,
    input  logic [7:0]      i_prel,
    input  logic [7:0]      i_vrel,
    output rcs_pkg::t_match o_match
);

    logic w_sink_eq;
    logic w_prel_eq;
    logic w_vrel_eq;

    assign w_sink_eq = (i_slot.sink == i_sink);
    assign w_prel_eq = (i_slot.prel != UNUSED_CODE) && (i_slot.prel == i_prel);
    assign w_vrel_eq = (i_vrel != UNUSED_CODE) && (i_slot.vrel != UNUSED_CODE)
                       && (i_slot.vrel == i_vrel);

    // Priority pick; inactive and own slots are skipped
    always_comb begin
        o_match.hit    = 1'b0;
        o_match.status = rcs_pkg::ST_OK;
        if (i_slot.active && !i_own) begin
            if (w_sink_eq) begin
                o_match.hit    = 1'b1;
                o_match.status = rcs_pkg::ST_SINK_BUSY;
            end else if (w_prel_eq) begin
                o_match.hit    = 1'b1;
                o_match.status = rcs_pkg::ST_RELAY_BUSY;
            end else if (w_vrel_eq) begin
                o_match.hit    = 1'b1;
                o_match.status = rcs_pkg::ST_VALVE_BUSY;
            end
        end
    end

endmodule

FILE: sv/route_conflict_scoreboard_core.sv
// ----------------------------------------------------------------------------
// route_conflict_scoreboard_core
// Per-pump route reservation scoreboard with a serial conflict scan.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  request | in        | i_valid / o_stall  | mode, pump_index, sink, relays
//  result  | out       | o_valid / i_stall  | status, conflict_entry
//
// A check that reaches the scan walks the slots from index 0 upward: one
// slot goes through the shared compare unit per cycle, and the scan stops at
// the first conflict. Other requests skip the scan.
// o_stall is high from acceptance until the result is in the output register.
// A stalled result holds the block in its final state until taken.
// Reset is synchronous, active low, and empties all slots at once.
// ----------------------------------------------------------------------------
module route_conflict_scoreboard_core #(
    parameter int         ENTRIES     = rcs_pkg::DEF_ENTRIES,
    parameter logic [7:0] UNUSED_CODE = rcs_pkg::DEF_UNUSED_CODE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_pump_index,
    input  logic [3:0] i_sink_role,
    input  logic [7:0] i_pump_relay,
    input  logic [7:0] i_valve_relay,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [2:0] o_conflict_entry
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [8:0]       NUM_ENT  = 9'(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [IDX_W-1:0] r_pump,  n_pump;
    logic [3:0]       r_sink,  n_sink;
    logic [7:0]       r_prel,  n_prel;
    logic [7:0]       r_vrel,  n_vrel;
    logic [2:0]       r_res_status, n_res_status;
    logic [2:0]       r_res_entry,  n_res_entry;
    logic             r_out_valid,  n_out_valid;
    logic [2:0]       r_out_status, n_out_status;
    logic [2:0]       r_out_entry,  n_out_entry;

    logic             w_accept;
    logic             w_pump_ok;
    logic             w_load;
    rcs_pkg::t_wr_ctl w_wr;
    rcs_pkg::t_slot   w_slot;
    rcs_pkg::t_match  w_match;

    assign w_accept  = i_valid && !o_stall;
    assign w_pump_ok = ({1'b0, i_pump_index} < NUM_ENT);
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // Store write controls, taken straight from the accepted item
    always_comb begin
        w_wr.wr_en   = w_accept && (i_mode == rcs_pkg::MODE_RESERVE) && w_pump_ok;
        w_wr.clr_all = w_accept && (i_mode == rcs_pkg::MODE_CLEAR);
    end

    rcs_slot_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_idx  (i_pump_index[IDX_W-1:0]),
        .i_wr_sink (i_sink_role),
        .i_wr_prel (i_pump_relay),
        .i_wr_vrel (i_valve_relay),
        .i_rd_idx  (r_idx),
        .o_rd_slot (w_slot)
    );

    rcs_match_unit #(
        .UNUSED_CODE (UNUSED_CODE)
    ) u_match (
        .i_slot  (w_slot),
        .i_own   (r_idx == r_pump),
        .i_sink  (r_sink),
        .i_prel  (r_prel),
        .i_vrel  (r_vrel),
        .o_match (w_match)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pump       = r_pump;
        n_sink       = r_sink;
        n_prel       = r_prel;
        n_vrel       = r_vrel;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pump       = i_pump_index[IDX_W-1:0];
                    n_sink       = i_sink_role;
                    n_prel       = i_pump_relay;
                    n_vrel       = i_valve_relay;
                    n_idx        = '0;
                    n_res_status = rcs_pkg::ST_OK;
                    n_res_entry  = '0;
                    n_state      = S_DONE;
                    if (i_mode == rcs_pkg::MODE_CHECK) begin
                        if (!w_pump_ok) begin
                            n_res_status = rcs_pkg::ST_BAD_PUMP;
                        end else if (i_sink_role == 4'd0) begin
                            n_res_status = rcs_pkg::ST_NO_SINK;
                        end else if (i_pump_relay == UNUSED_CODE) begin
                            n_res_status = rcs_pkg::ST_NO_RELAY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_mode == rcs_pkg::MODE_RESERVE && !w_pump_ok) begin
                        n_res_status = rcs_pkg::ST_BAD_PUMP;
                    end
                end
            end
            S_SCAN: begin
                if (w_match.hit) begin
                    n_res_status = w_match.status;
                    n_res_entry  = 3'(r_idx);
                    n_state      = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out_entry  = r_res_entry;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pump       <= n_pump;
        r_sink       <= n_sink;
        r_prel       <= n_prel;
        r_vrel       <= n_vrel;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_conflict_entry = r_out_entry;

`ifndef ASSERT_OFF
    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("block not busy after accepting an item");

    // Only busy statuses carry a slot index
    a_entry_only_on_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !(o_status == rcs_pkg::ST_SINK_BUSY
                   || o_status == rcs_pkg::ST_RELAY_BUSY
                   || o_status == rcs_pkg::ST_VALVE_BUSY)) |-> (o_conflict_entry == 3'd0))
        else $error("conflict entry set without a busy status");

    // A finished result is loaded and the sequencer returns to idle
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("finished result not loaded into output register");

    // The scan never leaves the slot range
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("scan index beyond last slot");
`endif

endmodule
